>>> src/swmm_pkg.sv
// shared constants and types for the sliding window min/max block
`default_nettype none

package swmm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int DATA_WIDTH = 32;

  // window_len register width is fixed by the register map
  localparam int WLEN_W = 7;
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int NUM_CELLS = MAX_WINDOW - 1;
  localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  // configuration port
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = CFG_IDX_W'(1);

  // combine operation codes
  localparam logic MODE_MIN = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // running minimum and maximum held by one cell
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] lo;
    logic signed [DATA_WIDTH-1:0] hi;
  } minmax_t;

endpackage

`default_nettype wire

>>> src/swmm_if.sv
// stream and configuration interfaces of the sliding window min/max block
`default_nettype none

interface swmm_sample_if;
  import swmm_pkg::*;
  logic  valid;
  logic  ready;
  data_t sample;
  logic  start_req;
  modport source (output valid, output sample, output start_req, input ready);
  modport sink (input valid, input sample, input start_req, output ready);
endinterface

interface swmm_result_if;
  import swmm_pkg::*;
  logic  valid;
  logic  ready;
  data_t window_result;
  modport source (output valid, output window_result, input ready);
  modport sink (input valid, input window_result, output ready);
endinterface

interface swmm_cfg_if;
  import swmm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/swmm_cell.sv
// one cell of the min/max chain: folds the new sample into its neighbor's pair
`default_nettype none

module swmm_cell (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire swmm_pkg::data_t   sample,
  input  wire swmm_pkg::minmax_t prev,
  output swmm_pkg::minmax_t      cur
);
  import swmm_pkg::*;

  minmax_t cur_next;

  always_comb begin
    cur_next.lo = (sample < prev.lo) ? sample : prev.lo;
    cur_next.hi = (sample > prev.hi) ? sample : prev.hi;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur <= cur_next;
    end
  end

endmodule

`default_nettype wire

>>> src/sliding_window_min_max.sv
// top level of the sliding window min/max block
// One sample is taken per clock cycle whenever the result register is empty
// or being drained, so a stream runs at one sample per cycle; the result of a
// sample appears in the result register in the cycle after its transfer. The
// window is held by a chain of MAX_WINDOW-1 cells: after each sample, cell k
// holds the minimum and the maximum of the newest k+1 samples, so both modes
// stay correct across a mode change. A result is the new sample folded with
// the pair of cell window_len-2, picked by a mux and one signed compare; that
// mux plus compare sets the cycle time. A start request clears the fill count,
// and no result is given until window_len samples of the current array are in.
// window_len above MAX_WINDOW acts as MAX_WINDOW, and zero never gives results.
`default_nettype none

module sliding_window_min_max (
  input  wire logic  clk,
  input  wire logic  rst,
  swmm_sample_if.sink   stream,
  swmm_result_if.source result,
  swmm_cfg_if.sink      cfg
);
  import swmm_pkg::*;

  // configuration registers
  logic [WLEN_W-1:0] window_len;
  logic              op_mode;

  // fill count of the current array, saturating at MAX_WINDOW
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_count_next;

  // result register
  logic  out_valid;
  data_t out_data;

  logic              accept;
  logic [FILL_W-1:0] win_eff;
  logic              emit;
  logic [IDX_W-1:0]  cell_sel;
  minmax_t           picked;
  data_t             result_next;

  minmax_t cells [NUM_CELLS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WLEN_W'(1);
      op_mode    <= MODE_MIN;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_WINDOW_LEN: window_len <= WLEN_W'(cfg.data);
        CFG_OP_MODE:    op_mode    <= cfg.data[0];
        default: ;  // writes beyond the register map are dropped
      endcase
    end
  end

  // skid: take a new sample while the held result is being drained
  assign stream.ready = !out_valid || result.ready;
  assign accept       = stream.valid && stream.ready;

  // chain of cells; cell 0 sees the sample itself as its neighbor
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    minmax_t prev;
    if (k == 0) begin : g_first
      assign prev = '{lo: stream.sample, hi: stream.sample};
    end else begin : g_rest
      assign prev = cells[k-1];
    end
    swmm_cell u_cell (
      .clk    (clk),
      .en     (accept),
      .sample (stream.sample),
      .prev   (prev),
      .cur    (cells[k])
    );
  end

  // fill count after this sample
  always_comb begin
    fill_base = stream.start_req ? '0 : fill_count;
    if (32'(fill_base) >= MAX_WINDOW) begin
      fill_count_next = fill_base;
    end else begin
      fill_count_next = fill_base + FILL_W'(1);
    end
  end

  // effective window length, clamped to MAX_WINDOW
  always_comb begin
    if (32'(window_len) > MAX_WINDOW) begin
      win_eff = FILL_W'(MAX_WINDOW);
    end else begin
      win_eff = FILL_W'(window_len);
    end
    emit = (win_eff != '0) && (fill_count_next >= win_eff);
  end

  // cell window_len-2 holds the best of the previous window_len-1 samples
  always_comb begin
    if (win_eff >= FILL_W'(2)) begin
      cell_sel = IDX_W'(win_eff - FILL_W'(2));
    end else begin
      cell_sel = '0;
    end
    picked = cells[cell_sel];
    if (win_eff < FILL_W'(2)) begin
      result_next = stream.sample;
    end else if (op_mode == MODE_MAX) begin
      result_next = (stream.sample > picked.hi) ? stream.sample : picked.hi;
    end else begin
      result_next = (stream.sample < picked.lo) ? stream.sample : picked.lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else if (accept) begin
      fill_count <= fill_count_next;
      out_valid  <= emit;
    end else if (result.ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.window_result = out_data;

endmodule

`default_nettype wire
